@@ rtl/c8ie_pkg.sv @@
// c8ie_pkg: shared types, opcode codes and default sizes for the CHIP-8 execute block.
// No dependencies; compiled first.
package c8ie_pkg;

    // Default sizes handed to the top level parameters
    localparam int STACK_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF     = 12;
    localparam int PC_START          = 'h200;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_UNDERFLOW   = 2'd3
    } t_status;

    // Opcode groups (instruction bits 15:12)
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;
    localparam logic [3:0] OP_JP_V0   = 4'hB;
    localparam logic [3:0] OP_RND     = 4'hC;

    // System call low bytes (with X = 0)
    localparam logic [7:0] SYS_CLS = 8'hE0;
    localparam logic [7:0] SYS_RET = 8'hEE;

    // 8XYN selectors
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [3:0] VF_IDX = 4'hF;

    // Register-file effect of one instruction
    typedef struct packed {
        logic       wr_x;    // write VX
        logic [7:0] vx_new;
        logic       wr_f;    // write VF (flag), applied before VX
        logic [7:0] flag;
        logic       skip;    // skip next instruction
    } t_alu_res;

endpackage

@@ rtl/c8ie_if.sv @@
// c8ie_if: valid/ready channel interfaces for instruction beats and result beats.
// No dependencies.
interface c8ie_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] instruction;
    logic [7:0]  random_byte;

    modport source (output valid, instruction, random_byte, input ready);
    modport sink   (input valid, instruction, random_byte, output ready);
endinterface

interface c8ie_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic [7:0]  vx_value;
    logic [7:0]  vf_value;
    logic [4:0]  stack_level;
    logic [1:0]  status;

    modport source (output valid, next_pc, index_value, vx_value, vf_value,
                    stack_level, status, input ready);
    modport sink   (input valid, next_pc, index_value, vx_value, vf_value,
                    stack_level, status, output ready);
endinterface

@@ rtl/chip8_instruction_execute.sv @@
// CHIP-8 execute core: one instruction beat in, one result beat out.
// An accepted instruction beat waits in the input register, then executes into the result
// register, which holds the result until taken and stalls execution while full and not
// drained. Throughput: one instruction per cycle unless results stall; the register file,
// index, PC and stack all update on execute, so dependent instructions may follow directly.
// Reset (i_rst_n low, synchronous): V registers and index cleared, PC = 0x200, stack empty,
// both pipeline registers empty. Stack memory contents are not cleared.
module chip8_instruction_execute
    import c8ie_pkg::*;
#(
    parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c8ie_in_if.sink    i_in,
    c8ie_out_if.source o_out
);

    localparam int CNT_W = $clog2(STACK_ENTRIES + 1);

    // Input register
    logic        r_in_valid;
    logic [15:0] r_instr;
    logic [7:0]  r_rnd;

    // Architectural state
    logic [7:0]           r_v [16];
    logic [11:0]          r_index;
    logic [ADDR_BITS-1:0] r_pc;

    // Result register
    logic        r_out_valid;
    logic [11:0] r_out_pc;
    logic [11:0] r_out_index;
    logic [7:0]  r_out_vx;
    logic [7:0]  r_out_vf;
    logic [4:0]  r_out_level;
    t_status     r_out_status;

    // Execute signals
    logic                 adv;
    logic [3:0]           kind;
    logic [3:0]           x_idx;
    logic [11:0]          nnn;
    logic [ADDR_BITS-1:0] pc_inc;
    logic [ADDR_BITS-1:0] pc_skip;
    logic [ADDR_BITS-1:0] n_pc;
    logic [11:0]          n_index;
    t_status              status;
    logic                 push;
    logic                 pop;
    t_alu_res             alu;
    logic [7:0]           vx_after;
    logic [7:0]           vf_after;
    logic [CNT_W-1:0]     n_level;

    // Stack interface
    logic [ADDR_BITS-1:0] stk_tos;
    logic [CNT_W-1:0]     stk_count;
    logic                 stk_empty;
    logic                 stk_full;

    assign kind  = r_instr[15:12];
    assign x_idx = r_instr[11:8];
    assign nnn   = r_instr[11:0];

    // Handshake: execute when the result register is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_instr <= i_in.instruction;
            r_rnd   <= i_in.random_byte;
        end
    end

    // Register data path
    c8ie_alu u_alu (
        .i_instr (r_instr),
        .i_rnd   (r_rnd),
        .i_vx    (r_v[x_idx]),
        .i_vy    (r_v[r_instr[7:4]]),
        .o_res   (alu)
    );

    // Return stack
    c8ie_stack #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .ADDR_BITS     (ADDR_BITS),
        .CNT_W         (CNT_W)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (pop),
        .i_push_addr (pc_inc),
        .o_tos       (stk_tos),
        .o_count     (stk_count),
        .o_empty     (stk_empty),
        .o_full      (stk_full)
    );

    assign pc_inc  = r_pc + ADDR_BITS'(2);
    assign pc_skip = r_pc + ADDR_BITS'(4);

    // Control flow decode
    always_comb begin
        n_pc    = alu.skip ? pc_skip : pc_inc;
        n_index = r_index;
        status  = ST_OK;
        push    = 1'b0;
        pop     = 1'b0;
        unique case (kind) inside
            OP_SYS: begin
                if (x_idx == 4'h0 && r_instr[7:0] == SYS_CLS) begin
                    status = ST_UNSUPPORTED;
                end else if (x_idx == 4'h0 && r_instr[7:0] == SYS_RET) begin
                    if (stk_empty) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        pop  = adv;
                        n_pc = stk_tos;
                    end
                end
            end
            OP_JP: n_pc = ADDR_BITS'(nnn);
            OP_CALL: begin
                if (stk_full) begin
                    status = ST_OVERFLOW;
                end else begin
                    push = adv;
                    n_pc = ADDR_BITS'(nnn);
                end
            end
            OP_SE_IMM, OP_SNE_IMM, OP_SE_REG, OP_SNE_REG,
            OP_LD_IMM, OP_ADD_IMM, OP_ALU, OP_RND: ;
            OP_LD_I:  n_index = nnn;
            OP_JP_V0: n_pc = ADDR_BITS'(nnn) + ADDR_BITS'(r_v[0]);
            default:  status = ST_UNSUPPORTED;
        endcase
    end

    // Values after the write-back; VX is written after VF
    always_comb begin
        vf_after = r_v[VF_IDX];
        if (alu.wr_f) begin
            vf_after = alu.flag;
        end
        if (alu.wr_x && x_idx == VF_IDX) begin
            vf_after = alu.vx_new;
        end
        vx_after = r_v[x_idx];
        if (alu.wr_f && x_idx == VF_IDX) begin
            vx_after = alu.flag;
        end
        if (alu.wr_x) begin
            vx_after = alu.vx_new;
        end
    end

    assign n_level = push ? stk_count + CNT_W'(1) :
                     pop  ? stk_count - CNT_W'(1) : stk_count;

    // Architectural state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_v[i] <= '0;
            end
            r_index <= '0;
            r_pc    <= ADDR_BITS'(PC_START);
        end else if (adv) begin
            for (int i = 0; i < 16; i++) begin
                if (alu.wr_x && x_idx == 4'(i)) begin
                    r_v[i] <= alu.vx_new;
                end else if (alu.wr_f && i == 15) begin
                    r_v[i] <= alu.flag;
                end
            end
            r_index <= n_index;
            r_pc    <= n_pc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pc     <= n_pc[11:0];
            r_out_index  <= n_index;
            r_out_vx     <= vx_after;
            r_out_vf     <= vf_after;
            r_out_level  <= 5'(n_level);
            r_out_status <= status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.next_pc     = r_out_pc;
    assign o_out.index_value = r_out_index;
    assign o_out.vx_value    = r_out_vx;
    assign o_out.vf_value    = r_out_vf;
    assign o_out.stack_level = r_out_level;
    assign o_out.status      = r_out_status;

    // Stack depth never passes its capacity
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_count <= CNT_W'(STACK_ENTRIES))
        else $error("stack depth beyond capacity");

    // An overflowing call leaves the stack depth alone
    a_overflow_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && status == ST_OVERFLOW |=> $stable(stk_count))
        else $error("stack changed on overflow");

    // A plain jump lands on its target
    a_jump_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && kind == OP_JP |=> r_pc == ADDR_BITS'($past(nnn)))
        else $error("jump target mismatch");

    // Underflow is only reported with an empty stack
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_UNDERFLOW |-> r_out_level == 5'd0)
        else $error("underflow with nonempty stack");

endmodule

@@ rtl/c8ie_alu.sv @@
// c8ie_alu: V-register data path: immediates, 8XYN group with flags, RND and skip tests.
// Depends on c8ie_pkg.
module c8ie_alu
    import c8ie_pkg::*;
(
    input  logic [15:0] i_instr,
    input  logic [7:0]  i_rnd,
    input  logic [7:0]  i_vx,
    input  logic [7:0]  i_vy,
    output t_alu_res    o_res
);

    logic [3:0] kind;
    logic [3:0] sel;
    logic [7:0] nn;
    logic [8:0] sum_xy;
    logic [7:0] sub_xy;
    logic [7:0] sub_yx;

    assign kind   = i_instr[15:12];
    assign sel    = i_instr[3:0];
    assign nn     = i_instr[7:0];
    assign sum_xy = {1'b0, i_vx} + {1'b0, i_vy};
    assign sub_xy = i_vx - i_vy;
    assign sub_yx = i_vy - i_vx;

    // Decode and compute
    always_comb begin
        o_res = '0;
        unique case (kind)
            OP_SE_IMM:  o_res.skip = (i_vx == nn);
            OP_SNE_IMM: o_res.skip = (i_vx != nn);
            OP_SE_REG:  o_res.skip = (i_vx == i_vy);
            OP_SNE_REG: o_res.skip = (i_vx != i_vy);
            OP_LD_IMM: begin
                o_res.wr_x   = 1'b1;
                o_res.vx_new = nn;
            end
            OP_ADD_IMM: begin
                o_res.wr_x   = 1'b1;
                o_res.vx_new = i_vx + nn;
            end
            OP_RND: begin
                o_res.wr_x   = 1'b1;
                o_res.vx_new = i_rnd & nn;
            end
            OP_ALU: begin
                unique case (sel)
                    ALU_LD: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = i_vy;
                    end
                    ALU_OR: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = i_vx | i_vy;
                    end
                    ALU_AND: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = i_vx & i_vy;
                    end
                    ALU_XOR: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = i_vx ^ i_vy;
                    end
                    ALU_ADD: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = sum_xy[7:0];
                        o_res.wr_f   = 1'b1;
                        o_res.flag   = {7'd0, sum_xy[8]};
                    end
                    ALU_SUB: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = sub_xy;
                        o_res.wr_f   = 1'b1;
                        o_res.flag   = {7'd0, (i_vx >= i_vy)};
                    end
                    ALU_SHR: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = {1'b0, i_vx[7:1]};
                        o_res.wr_f   = 1'b1;
                        o_res.flag   = {7'd0, i_vx[0]};
                    end
                    ALU_SUBN: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = sub_yx;
                        o_res.wr_f   = 1'b1;
                        o_res.flag   = {7'd0, (i_vy >= i_vx)};
                    end
                    ALU_SHL: begin
                        o_res.wr_x   = 1'b1;
                        o_res.vx_new = {i_vx[6:0], 1'b0};
                        o_res.wr_f   = 1'b1;
                        o_res.flag   = {7'd0, i_vx[7]};
                    end
                    default: ;  // undefined selector: no operation
                endcase
            end
            default: ;  // no register-file effect
        endcase
    end

endmodule

@@ rtl/c8ie_stack.sv @@
// c8ie_stack: return-address stack in a memory with a registered top-of-stack copy.
// Depends on c8ie_pkg for the default sizes.
module c8ie_stack
    import c8ie_pkg::*;
#(
    parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF,
    parameter int CNT_W         = $clog2(STACK_ENTRIES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,      // only when not full
    input  logic                 i_pop,       // only when not empty
    input  logic [ADDR_BITS-1:0] i_push_addr,
    output logic [ADDR_BITS-1:0] o_tos,
    output logic [CNT_W-1:0]     o_count,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int IDX_W = $clog2(STACK_ENTRIES);

    logic [ADDR_BITS-1:0] r_mem [STACK_ENTRIES];
    logic [ADDR_BITS-1:0] r_tos;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     rd_cnt;
    logic [IDX_W-1:0]     rd_ptr;

    // Depth counter
    always_comb begin
        n_count = r_count;
        if (i_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Read the entry that becomes top of stack after this beat
    assign rd_cnt = r_count - (i_pop ? CNT_W'(2) : CNT_W'(1));
    assign rd_ptr = rd_cnt[IDX_W-1:0];

    // Memory write and registered read; a push makes the written address the new top
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_count[IDX_W-1:0]] <= i_push_addr;
            r_tos <= i_push_addr;
        end else begin
            r_tos <= r_mem[rd_ptr];
        end
    end

    assign o_tos   = r_tos;
    assign o_count = r_count;
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(STACK_ENTRIES));

endmodule

@@ tb/tb_chip8_instruction_execute.sv @@
// Self-checking testbench for chip8_instruction_execute: directed and random instruction beats,
// checked against a cycle-free model of the V registers, index, PC and return stack.
// Depends on rtl/c8ie_pkg.sv, rtl/c8ie_if.sv and rtl/chip8_instruction_execute.sv.
`timescale 1ns / 100ps

module tb_chip8_instruction_execute;
    import c8ie_pkg::*;

    localparam int STACK_DEPTH  = STACK_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Opcode groups the block does not execute
    localparam logic [3:0] OP_DRAW    = 4'hD;
    localparam logic [3:0] OP_KEY_SKP = 4'hE;
    localparam logic [3:0] OP_MISC    = 4'hF;

    typedef struct {
        logic [11:0] next_pc;
        logic [11:0] index_value;
        logic [7:0]  vx_value;
        logic [7:0]  vf_value;
        logic [4:0]  stack_level;
        t_status     status;
    } t_exec_result;

    // Machine state tracker and queue of expected result beats
    class c8_exec_scoreboard;
        logic [7:0]   vreg [16];
        logic [11:0]  index_reg;
        logic [11:0]  pc;
        logic [11:0]  return_addr [STACK_DEPTH];
        int           depth;
        t_exec_result expected_results [$];
        int           errors;

        function new();
            foreach (vreg[i]) vreg[i] = 8'h00;
            index_reg = 12'h000;
            pc        = 12'(PC_START);
            depth     = 0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Execute one accepted instruction beat and queue its result
        function void note_instruction(logic [15:0] op, logic [7:0] rnd);
            logic [3:0]   grp, x, y, sel;
            logic [7:0]   nn, a, b;
            logic [11:0]  nnn;
            logic [8:0]   sum;
            logic         skip;
            t_status      st;
            t_exec_result res;
            grp  = op[15:12];
            x    = op[11:8];
            y    = op[7:4];
            sel  = op[3:0];
            nn   = op[7:0];
            nnn  = op[11:0];
            skip = 1'b0;
            st   = ST_OK;
            pc   = pc + 12'd2;
            case (grp)
                OP_SYS: begin
                    if (x == 4'h0 && nn == SYS_CLS) begin
                        st = ST_UNSUPPORTED;
                    end else if (x == 4'h0 && nn == SYS_RET) begin
                        if (depth == 0) begin
                            st = ST_UNDERFLOW;
                        end else begin
                            depth = depth - 1;
                            pc    = return_addr[depth];
                        end
                    end
                end
                OP_JP: pc = nnn;
                OP_CALL: begin
                    if (depth >= STACK_DEPTH) begin
                        st = ST_OVERFLOW;
                    end else begin
                        return_addr[depth] = pc;
                        depth = depth + 1;
                        pc    = nnn;
                    end
                end
                OP_SE_IMM:  skip = (vreg[x] == nn);
                OP_SNE_IMM: skip = (vreg[x] != nn);
                OP_SE_REG:  skip = (vreg[x] == vreg[y]);
                OP_LD_IMM:  vreg[x] = nn;
                OP_ADD_IMM: vreg[x] = vreg[x] + nn;
                OP_ALU: begin
                    a = vreg[x];
                    b = vreg[y];
                    // flag lands first so the result wins when X is VF
                    case (sel)
                        ALU_LD:  vreg[x] = b;
                        ALU_OR:  vreg[x] = a | b;
                        ALU_AND: vreg[x] = a & b;
                        ALU_XOR: vreg[x] = a ^ b;
                        ALU_ADD: begin
                            sum            = {1'b0, a} + {1'b0, b};
                            vreg[VF_IDX]   = {7'd0, sum[8]};
                            vreg[x]        = sum[7:0];
                        end
                        ALU_SUB: begin
                            vreg[VF_IDX] = (a >= b) ? 8'd1 : 8'd0;
                            vreg[x]      = a - b;
                        end
                        ALU_SHR: begin
                            vreg[VF_IDX] = {7'd0, a[0]};
                            vreg[x]      = {1'b0, a[7:1]};
                        end
                        ALU_SUBN: begin
                            vreg[VF_IDX] = (b >= a) ? 8'd1 : 8'd0;
                            vreg[x]      = b - a;
                        end
                        ALU_SHL: begin
                            vreg[VF_IDX] = {7'd0, a[7]};
                            vreg[x]      = {a[6:0], 1'b0};
                        end
                        default: ;
                    endcase
                end
                OP_SNE_REG: skip = (vreg[x] != vreg[y]);
                OP_LD_I:    index_reg = nnn;
                OP_JP_V0:   pc = nnn + {4'd0, vreg[0]};
                OP_RND:     vreg[x] = rnd & nn;
                default:    st = ST_UNSUPPORTED;
            endcase
            if (skip) pc = pc + 12'd2;

            res.next_pc     = pc;
            res.index_value = index_reg;
            res.vx_value    = vreg[x];
            res.vf_value    = vreg[VF_IDX];
            res.stack_level = 5'(depth);
            res.status      = st;
            expected_results.push_back(res);
        endfunction

        // Compare one result beat against the oldest expectation
        function void check_result(t_exec_result got);
            t_exec_result exp_res;
            if (expected_results.size() == 0) begin
                $error("result beat with no instruction outstanding, next_pc %0h", got.next_pc);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.next_pc !== exp_res.next_pc) begin
                $error("next_pc: expected %0h, got %0h", exp_res.next_pc, got.next_pc);
                errors++;
            end
            if (got.index_value !== exp_res.index_value) begin
                $error("index_value: expected %0h, got %0h", exp_res.index_value,
                       got.index_value);
                errors++;
            end
            if (got.vx_value !== exp_res.vx_value) begin
                $error("vx_value: expected %0h, got %0h", exp_res.vx_value, got.vx_value);
                errors++;
            end
            if (got.vf_value !== exp_res.vf_value) begin
                $error("vf_value: expected %0h, got %0h", exp_res.vf_value, got.vf_value);
                errors++;
            end
            if (got.stack_level !== exp_res.stack_level) begin
                $error("stack_level: expected %0d, got %0d", exp_res.stack_level,
                       got.stack_level);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_quiet;

    c8_exec_scoreboard board;

    c8ie_in_if  instr_ch ();
    c8ie_out_if result_ch ();

    chip8_instruction_execute dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Wait before the next beat; now and then a stretch with no waiting at all
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Random instruction word; group 0 leans toward CLS and RET
    function automatic logic [15:0] any_instruction();
        logic [15:0] word;
        word = 16'($urandom);
        if (word[15:12] == OP_SYS) begin
            case ($urandom_range(0, 2))
                0: word = {OP_SYS, 4'h0, SYS_CLS};
                1: word = {OP_SYS, 4'h0, SYS_RET};
                default: ;
            endcase
        end
        return word;
    endfunction

    // Present one instruction beat and hold it until accepted
    task automatic send_instruction(input logic [15:0] op, input logic [7:0] rnd);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap != 0) begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        instr_ch.valid       <= 1'b1;
        instr_ch.instruction <= op;
        instr_ch.random_byte <= rnd;
        do @(posedge i_clk); while (instr_ch.ready !== 1'b1);
        board.note_instruction(op, rnd);
    endtask

    // Result side: random stalls, check every accepted beat
    initial begin : result_sink
        int           stall;
        int           recv_quiet;
        t_exec_result got;
        recv_quiet = 0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_wait(recv_quiet);
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
            got.next_pc     = result_ch.next_pc;
            got.index_value = result_ch.index_value;
            got.vx_value    = result_ch.vx_value;
            got.vf_value    = result_ch.vf_value;
            got.stack_level = result_ch.stack_level;
            got.status      = t_status'(result_ch.status);
            board.check_result(got);
        end
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("chip8_instruction_execute regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] directed_ops [$];
        logic [3:0]  x, y;
        logic [7:0]  nn;
        int          n_calls, n_filler, n_rets;
        int          random_items;
        bit          overflow_seen;

        board         = new();
        send_quiet    = 0;
        random_items  = 0;
        overflow_seen = 1'b0;
        i_rst_n              <= 1'b0;
        instr_ch.valid       <= 1'b0;
        instr_ch.instruction <= 16'h0000;
        instr_ch.random_byte <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every operation, the corner cases
        directed_ops = '{
            {OP_LD_IMM, 4'h0, 8'hFF},
            {OP_ADD_IMM, 4'h0, 8'h01},         // immediate add wraps, VF untouched
            {OP_LD_IMM, 4'h1, 8'hFF},
            {OP_LD_IMM, 4'hF, 8'hFF},
            {OP_ALU, 4'hF, 4'h1, ALU_ADD},     // flag and result both in VF
            {OP_ALU, 4'h1, 4'h1, ALU_ADD},     // carry out
            {OP_ALU, 4'h0, 4'h1, ALU_SUB},     // borrow
            {OP_ALU, 4'h0, 4'h1, ALU_SUBN},
            {OP_ALU, 4'h1, 4'h1, ALU_SHR},
            {OP_ALU, 4'h1, 4'h0, ALU_SHL},
            {OP_ALU, 4'h2, 4'h1, ALU_LD},
            {OP_ALU, 4'h2, 4'h0, ALU_OR},
            {OP_ALU, 4'h2, 4'h1, ALU_AND},
            {OP_ALU, 4'h2, 4'h0, ALU_XOR},
            {OP_ALU, 4'h2, 4'h1, 4'hC},        // undefined selector
            {OP_SYS, 4'h0, SYS_CLS},
            {OP_SYS, 4'h0, SYS_RET},           // return with empty stack
            {OP_SYS, 12'hFFF},                 // plain system call
            {OP_CALL, 12'hFFE},
            {OP_SYS, 4'h0, SYS_RET},
            {OP_SE_IMM, 4'h0, 8'hFC},
            {OP_SNE_IMM, 4'hF, 8'h00},
            {OP_SE_REG, 4'h0, 4'h0, 4'hF},     // low nibble ignored
            {OP_SNE_REG, 4'h0, 4'h1, 4'h7},
            {OP_LD_I, 12'hFFF},
            {OP_JP_V0, 12'hFFF},               // target wraps past the top
            {OP_RND, 4'h5, 8'hFF},
            {OP_RND, 4'hA, 8'h5A},
            {OP_DRAW, 12'h123},
            {OP_KEY_SKP, 12'h09E},
            {OP_MISC, 12'hF65},
            {OP_JP, 12'h000}
        };
        foreach (directed_ops[i])
            send_instruction(directed_ops[i], {8{i[0]}});

        // Random: mostly well-formed sequences, the rest arbitrary words
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    // call chain, a little filler, then returns (often too many)
                    n_calls = overflow_seen ? $urandom_range(1, STACK_DEPTH + 2)
                                            : STACK_DEPTH + 2;
                    overflow_seen = 1'b1;
                    repeat (n_calls)
                        send_instruction({OP_CALL, 12'($urandom)}, 8'($urandom));
                    n_filler = $urandom_range(0, 3);
                    repeat (n_filler)
                        send_instruction(any_instruction(), 8'($urandom));
                    n_rets = $urandom_range(1, STACK_DEPTH + 3);
                    repeat (n_rets)
                        send_instruction({OP_SYS, 4'h0, SYS_RET}, 8'($urandom));
                    random_items += n_calls + n_filler + n_rets;
                end
                1, 2: begin
                    // load two registers, then one 8XYN on them
                    x = 4'($urandom);
                    y = 4'($urandom);
                    send_instruction({OP_LD_IMM, x, 8'($urandom)}, 8'($urandom));
                    send_instruction({OP_LD_IMM, y, 8'($urandom)}, 8'($urandom));
                    send_instruction({OP_ALU, x, y, 4'($urandom)}, 8'($urandom));
                    random_items += 3;
                end
                3: begin
                    // load a register, then a skip that hits about half the time
                    x  = 4'($urandom);
                    y  = 4'($urandom);
                    nn = 8'($urandom);
                    send_instruction({OP_LD_IMM, x, nn}, 8'($urandom));
                    if ($urandom_range(0, 1) == 0) nn = 8'($urandom);
                    case ($urandom_range(0, 3))
                        0: send_instruction({OP_SE_IMM, x, nn}, 8'($urandom));
                        1: send_instruction({OP_SNE_IMM, x, nn}, 8'($urandom));
                        2: send_instruction({OP_SE_REG, x, y, 4'($urandom)}, 8'($urandom));
                        default:
                            send_instruction({OP_SNE_REG, x, y, 4'($urandom)}, 8'($urandom));
                    endcase
                    random_items += 2;
                end
                default: begin
                    send_instruction(any_instruction(), 8'($urandom));
                    random_items += 1;
                end
            endcase
        end
        instr_ch.valid <= 1'b0;

        // Drain outstanding results, then allow stray beats to show up
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("chip8_instruction_execute regression: pass");
        else
            $display("chip8_instruction_execute regression: fail");
        $finish;
    end

endmodule
